// ===== hdl/srtu_pkg.sv =====
// ----------------------------------------------------------------------------
// srtu_pkg: shared types and codes for the sensor record table
// Status codes and the record layout carried along the cell chain.
// ----------------------------------------------------------------------------
package srtu_pkg;

  localparam logic [1:0] StUpdated  = 2'd0;
  localparam logic [1:0] StInserted = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StRejected = 2'd3;

  typedef struct packed {
    logic [7:0]  serial;
    logic [7:0]  kind;
    logic [7:0]  sid;
    logic [7:0]  age;
    logic [7:0]  rst;
    logic [7:0]  str;
    logic [31:0] cnt;
    logic [63:0] dlo;
    logic [47:0] dhi;
  } rec_t;

  // token handed from cell to cell during one pass
  typedef struct packed {
    logic       valid;
    logic       insert;   // second pass: claim first free slot
    logic       hit;      // something written so far in this pass
    logic [4:0] slot;
  } tok_t;

endpackage

// ===== hdl/srtu_cell.sv =====
// ----------------------------------------------------------------------------
// srtu_cell: one table slot
// Holds one record; compares against the item passing by and hands the token on.
// ----------------------------------------------------------------------------
module srtu_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srtu_pkg::rec_t  rec_i,
  input  srtu_pkg::tok_t  tok_i,
  output srtu_pkg::tok_t  tok_o
);

  srtu_pkg::rec_t ent_q;
  srtu_pkg::tok_t tok_q, tok_d;
  logic           match, free, wr;

  assign match = (ent_q.serial == rec_i.serial) && (ent_q.kind == rec_i.kind) &&
                 (ent_q.sid == rec_i.sid) && (ent_q.age >= rec_i.age) &&
                 ((ent_q.cnt < rec_i.cnt) || (ent_q.rst < rec_i.rst) ||
                  (ent_q.str > rec_i.str));
  assign free  = (ent_q.serial == 8'd0);
  assign wr    = tok_i.valid && (tok_i.insert ? (free && !tok_i.hit) : match);

  always_comb begin
    tok_d = tok_i;
    if (wr) begin
      tok_d.hit  = 1'b1;
      tok_d.slot = 5'(IDX % 32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      if (wr) ent_q <= rec_i;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/sensor_record_table_update.sv =====
// ----------------------------------------------------------------------------
// sensor_record_table_update: table of latest sensor records
// Channel | dir | handshake           | fields
// cmd     | in  | start_i / busy_o    | serial_number_i .. payload_high_i
// result  | out | done_o (one cycle)  | status_o, slot_o
// An item takes up to two passes of a token down the cell chain: update pass,
// then insert pass if nothing matched. Serial zero answers the next cycle.
// Reset clears all slots at once. The receiver cannot stall; busy_o is high
// until done_o.
// ----------------------------------------------------------------------------
module sensor_record_table_update #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  serial_number_i,
  input  logic [7:0]  record_kind_i,
  input  logic [7:0]  restart_count_i,
  input  logic [31:0] packet_count_i,
  input  logic [7:0]  sensor_id_i,
  input  logic [7:0]  hop_age_i,
  input  logic [7:0]  signal_strength_i,
  input  logic [63:0] payload_low_i,
  input  logic [47:0] payload_high_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  slot_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;

  logic [1:0]     state_q, state_d;
  srtu_pkg::rec_t rec_q;
  srtu_pkg::tok_t chain [TABLE_ENTRIES+1];
  srtu_pkg::tok_t launch_q, launch_d;
  logic           done_d;
  logic [1:0]     status_d;
  logic [4:0]     slot_d;
  srtu_pkg::tok_t tail;

  assign tail     = chain[TABLE_ENTRIES];
  assign chain[0] = launch_q;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    srtu_cell #(.IDX(g)) u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni), .rec_i(rec_q),
      .tok_i (chain[g]), .tok_o(chain[g+1])
    );
  end

  always_comb begin
    state_d  = state_q;
    launch_d = '0;
    done_d   = 1'b0;
    status_d = srtu_pkg::StRejected;
    slot_d   = '0;
    case (state_q)
      S_IDLE: if (start_i) begin
        if (serial_number_i == 8'd0) begin
          done_d = 1'b1;
        end else begin
          launch_d.valid = 1'b1;
          state_d        = S_UPD;
        end
      end
      S_UPD: if (tail.valid) begin
        if (tail.hit) begin
          done_d   = 1'b1;
          status_d = srtu_pkg::StUpdated;
          slot_d   = tail.slot;
          state_d  = S_IDLE;
        end else begin
          launch_d.valid  = 1'b1;
          launch_d.insert = 1'b1;
          state_d         = S_INS;
        end
      end
      S_INS: if (tail.valid) begin
        done_d   = 1'b1;
        status_d = tail.hit ? srtu_pkg::StInserted : srtu_pkg::StFull;
        slot_d   = tail.hit ? tail.slot : 5'd0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= '0;
      done_o   <= 1'b0;
      status_o <= '0;
      slot_o   <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      done_o   <= done_d;
      if (done_d) begin
        status_o <= status_d;
        slot_o   <= slot_d;
      end
    end
  end

  // hold the item for both passes
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      rec_q <= '{serial: serial_number_i, kind: record_kind_i, sid: sensor_id_i,
                 age: hop_age_i, rst: restart_count_i, str: signal_strength_i,
                 cnt: packet_count_i, dlo: payload_low_i, dhi: payload_high_i};
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
